// ===== design/indirect_block_map_walker_top_macros.svh =====
// assertion macros used by the block map walker top
`ifndef INDIRECT_BLOCK_MAP_WALKER_TOP_MACROS_SVH
`define INDIRECT_BLOCK_MAP_WALKER_TOP_MACROS_SVH

// same-cycle implication
`define IBMW_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ibmw: same-cycle check failed");

// next-cycle implication
`define IBMW_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ibmw: next-cycle check failed");

`endif

// ===== design/ibmw_pkg.sv =====
// shared types, codes and helpers of the block map walker
package ibmw_pkg;

	localparam int unsigned POINTER_SLOTS = 15;
	localparam int unsigned DIRECT_SLOTS  = 12;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned ADDR_W        = 44;

	typedef logic [1:0]        cmd_t;
	typedef logic [1:0]        kind_t;
	typedef logic [3:0]        slot_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [1:0]        cfg_index_t;

	localparam cmd_t CMD_LOAD = 2'd0;
	localparam cmd_t CMD_MAP  = 2'd1;
	localparam cmd_t CMD_WORD = 2'd2;

	localparam kind_t KIND_READ  = 2'd0;
	localparam kind_t KIND_DONE  = 2'd1;
	localparam kind_t KIND_ERROR = 2'd2;

	localparam cfg_index_t CFG_BLOCK_SHIFT = 2'd0;
	localparam cfg_index_t CFG_FIRST_DATA  = 2'd1;
	localparam cfg_index_t CFG_TOTAL       = 2'd2;

	// result of the shared subtractor
	typedef struct packed {
		word_t diff;
		logic  borrow;
	} sub_res_t;

	// a shift code of three behaves as two
	function automatic logic [1:0] eff_shift(input logic [1:0] bs);
		return (bs == 2'd3) ? 2'd2 : bs;
	endfunction

endpackage

// ===== design/ibmw_if.sv =====
// valid/ready channels for request and result transactions
interface ibmw_in_if;
	logic              valid;
	logic              ready;
	ibmw_pkg::cmd_t    cmd;
	ibmw_pkg::slot_t   slot;
	ibmw_pkg::word_t   word;
	ibmw_pkg::word_t   logical_block;

	modport source (output valid, output cmd, output slot, output word,
		output logical_block, input ready);
	modport sink (input valid, input cmd, input slot, input word,
		input logical_block, output ready);
endinterface

interface ibmw_out_if;
	logic              valid;
	logic              ready;
	ibmw_pkg::kind_t   kind;
	ibmw_pkg::addr_t   read_address;
	ibmw_pkg::word_t   mapped_block;

	modport source (output valid, output kind, output read_address,
		output mapped_block, input ready);
	modport sink (input valid, input kind, input read_address,
		input mapped_block, output ready);
endinterface

// ===== design/indirect_block_map_walker_top.sv =====
// block map walker: logical to device block translation by direct and indirect pointers
//
// in_ch carries one command per transaction: load a pointer slot, start a map
// request, or hand back a pointer word that was read from disk. out_ch carries
// at most one result per command: a read request (byte address of the next
// pointer word), a finished mapping (0 is a hole) or an error.
// configuration (block shift, first data block, total blocks) is written on
// cfg_en/cfg_index/cfg_data while nothing is in flight.
// in_ch.ready is high only while the sequencer sits in idle. a load, an
// ignored command, and anything else that gives no result leave it in idle.
// a direct map request or a returned word gives its result after the pointer
// slot read (or word capture), then one check on the shared subtractor.
// an indirect map request first takes its level search steps on the shared
// subtractor, then the slot read and check, or ends the search in an error
// when beyond triple indirect reach. a walk then waits for the returned word;
// commands other than that are accepted and dropped meanwhile.
// reset restores the configuration defaults and ends any walk; the pointer
// slots hold nothing until loaded and get no clearing pass.
// a stalled receiver holds the result in the output register; the sequencer
// waits in its last state until the register frees, so nothing is lost.
`include "indirect_block_map_walker_top_macros.svh"

module indirect_block_map_walker_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_en,
	input  ibmw_pkg::cfg_index_t    cfg_index,
	input  ibmw_pkg::word_t         cfg_data,
	ibmw_in_if.sink                 in_ch,
	ibmw_out_if.source              out_ch
);
	import ibmw_pkg::*;

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;	// waiting for a transaction
	localparam logic [1:0] S_LVL  = 2'd1;	// indirect level search
	localparam logic [1:0] S_CHK  = 2'd2;	// validate block, form result

	logic [1:0] state_q;

	// configuration
	logic [1:0] block_shift_q;
	logic       first_data_q;
	word_t      total_q;

	// pointer slots, no reset
	word_t      ptr_mem [POINTER_SLOTS];

	// walk state
	word_t      blk_q;		// block under check
	word_t      off_q;		// remaining offset
	logic [4:0] sh_q;		// span shift
	logic [1:0] lvl_q;		// levels left
	logic       busy_q;		// waiting for a returned word
	logic       fin_q;		// this check ends the mapping

	// output register
	logic       res_valid_q;
	kind_t      res_kind_q;
	addr_t      res_addr_q;
	word_t      res_blk_q;

	logic       in_acc;
	logic       res_free;
	logic [1:0] es;
	logic [3:0] ps;
	logic [3:0] addr_sh;
	word_t      sub_a;
	word_t      sub_b;
	sub_res_t   sub_res;
	logic       blk_ok;
	logic [4:0] span_new;
	word_t      idx;
	word_t      off_mask;
	addr_t      walk_addr;
	logic       mem_rd_en;
	slot_t      rd_slot;
	logic       res_load;
	kind_t      kind_d;
	addr_t      addr_d;
	word_t      blk_d;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	// the output register can take a new result this cycle
	assign res_free    = !res_valid_q || out_ch.ready;

	assign es      = eff_shift(block_shift_q);
	assign ps      = 4'd8 + {2'b00, es};	// log2 of pointers per block
	assign addr_sh = 4'd10 + {2'b00, es};	// log2 of block size in bytes

	// operand select for the shared unit
	always_comb begin
		unique case (state_q)
			S_LVL: begin
				sub_a = off_q;
				sub_b = word_t'(1) << sh_q;
			end
			default: begin
				sub_a = blk_q;
				sub_b = total_q;
			end
		endcase
	end

	ibmw_sub u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	// non-zero, not below first data block, below total blocks
	assign blk_ok = (blk_q != '0) && ((blk_q[WORD_W-1:1] != '0) || (blk_q[0] >= first_data_q))
		&& sub_res.borrow;

	// step down one level: index into this pointer block, keep the rest
	assign span_new  = (sh_q >= {1'b0, ps}) ? (sh_q - {1'b0, ps}) : 5'd0;
	assign idx       = off_q >> span_new;
	assign off_mask  = (word_t'(1) << span_new) - word_t'(1);
	assign walk_addr = ({{(ADDR_W-WORD_W){1'b0}}, blk_q} << addr_sh)
		+ {{(ADDR_W-WORD_W-2){1'b0}}, idx, 2'b00};

	// pointer slot read: direct slot at acceptance, indirect root after search
	always_comb begin
		mem_rd_en = 1'b0;
		rd_slot   = in_ch.logical_block[3:0];
		unique case (state_q)
			S_IDLE: begin
				mem_rd_en = in_acc && (in_ch.cmd == CMD_MAP) && !busy_q
					&& (in_ch.logical_block < WORD_W'(DIRECT_SLOTS));
			end
			S_LVL: begin
				mem_rd_en = sub_res.borrow;
				rd_slot   = slot_t'(DIRECT_SLOTS - 1) + {2'b00, lvl_q};
			end
			default: ;
		endcase
	end

	// result formation
	always_comb begin
		res_load = 1'b0;
		kind_d   = KIND_DONE;
		addr_d   = '0;
		blk_d    = '0;
		unique case (state_q)
			S_LVL: begin
				// beyond triple indirect reach
				if (!sub_res.borrow && (lvl_q == 2'd3)) begin
					res_load = res_free;
					kind_d   = KIND_ERROR;
				end
			end
			S_CHK: begin
				res_load = res_free;
				priority if (fin_q) begin
					if ((blk_q == '0) || blk_ok) begin
						blk_d = blk_q;
					end else begin
						kind_d = KIND_ERROR;
					end
				end else if (blk_q == '0) begin
					// hole inside the walk
					kind_d = KIND_DONE;
				end else if (!blk_ok) begin
					kind_d = KIND_ERROR;
				end else begin
					kind_d = KIND_READ;
					addr_d = walk_addr;
				end
			end
			default: ;
		endcase
	end

	// pointer slots and block register
	always_ff @(posedge clk) begin
		if (in_acc && (in_ch.cmd == CMD_LOAD) && !busy_q
			&& (in_ch.slot < slot_t'(POINTER_SLOTS))) begin
			ptr_mem[in_ch.slot] <= in_ch.word;
		end
		if (mem_rd_en) begin
			blk_q <= ptr_mem[rd_slot];
		end else if (in_acc && (in_ch.cmd == CMD_WORD) && busy_q) begin
			blk_q <= in_ch.word;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_kind_q <= kind_d;
			res_addr_q <= addr_d;
			res_blk_q  <= blk_d;
		end
	end

	// sequencer, walk state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			block_shift_q <= 2'd0;
			first_data_q  <= 1'b1;
			total_q       <= '0;
			off_q         <= '0;
			sh_q          <= '0;
			lvl_q         <= '0;
			busy_q        <= 1'b0;
			fin_q         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_en) begin
				unique case (cfg_index)
					CFG_BLOCK_SHIFT: block_shift_q <= cfg_data[1:0];
					CFG_FIRST_DATA:  first_data_q  <= cfg_data[0];
					CFG_TOTAL:       total_q       <= cfg_data;
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.cmd)
							CMD_MAP: begin
								if (!busy_q) begin
									if (in_ch.logical_block < WORD_W'(DIRECT_SLOTS)) begin
										fin_q   <= 1'b1;
										state_q <= S_CHK;
									end else begin
										off_q   <= in_ch.logical_block - WORD_W'(DIRECT_SLOTS);
										sh_q    <= {1'b0, ps};
										lvl_q   <= 2'd1;
										state_q <= S_LVL;
									end
								end
							end
							CMD_WORD: begin
								if (busy_q) begin
									lvl_q <= lvl_q - 2'd1;
									if (lvl_q == 2'd1) begin
										// last level: the word is the data block
										fin_q  <= 1'b1;
										busy_q <= 1'b0;
									end else begin
										fin_q <= 1'b0;
									end
									state_q <= S_CHK;
								end
							end
							default: ;
						endcase
					end
				end
				S_LVL: begin
					if (sub_res.borrow) begin
						// level found, root pointer is being read
						fin_q   <= 1'b0;
						state_q <= S_CHK;
					end else if (lvl_q == 2'd3) begin
						if (res_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						off_q <= sub_res.diff;
						sh_q  <= sh_q + {1'b0, ps};
						lvl_q <= lvl_q + 2'd1;
					end
				end
				S_CHK: begin
					if (res_free) begin
						state_q <= S_IDLE;
						if (!fin_q) begin
							if ((blk_q != '0) && blk_ok) begin
								busy_q <= 1'b1;
								sh_q   <= span_new;
								off_q  <= off_q & off_mask;
							end else begin
								busy_q <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid        = res_valid_q;
	assign out_ch.kind         = res_kind_q;
	assign out_ch.read_address = res_addr_q;
	assign out_ch.mapped_block = res_blk_q;

	// a walk in progress always has a level left
	`IBMW_ASSERT_NOW(a_busy_has_level, clk, arst_n, busy_q, lvl_q != 2'd0)
	// a read request leaves the walk waiting for its word
	`IBMW_ASSERT_NEXT(a_read_sets_busy, clk, arst_n, res_load && (kind_d == KIND_READ), busy_q)
	// only a finished mapping carries a block number
	`IBMW_ASSERT_NOW(a_blk_only_done, clk, arst_n,
		out_ch.valid && (out_ch.kind != KIND_DONE), out_ch.mapped_block == '0)
	// span shift stays within three levels of the widest block
	`IBMW_ASSERT_NOW(a_span_range, clk, arst_n, state_q != S_IDLE, sh_q <= 5'd30)

endmodule

// ===== design/ibmw_sub.sv =====
// shared 32-bit subtract and compare unit
module ibmw_sub (
	input  ibmw_pkg::word_t    a,
	input  ibmw_pkg::word_t    b,
	output ibmw_pkg::sub_res_t res
);
	import ibmw_pkg::*;

	logic [WORD_W:0] d;

	assign d          = {1'b0, a} - {1'b0, b};
	assign res.diff   = d[WORD_W-1:0];
	assign res.borrow = d[WORD_W];

endmodule

// ===== tb/indirect_block_map_walker_top_tb.sv =====
// self-checking testbench for the block map walker, with a scoreboard that predicts every result
`timescale 1ns / 1ps

module indirect_block_map_walker_top_tb;
	import ibmw_pkg::*;

	// command code that the block drops without a result
	localparam cmd_t CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int PHASES = 6;

	typedef struct {
		kind_t kind;
		addr_t addr;
		word_t blk;
	} map_result_t;

	// predicts the walker and keeps the results still owed by the block
	class map_scoreboard;
		word_t pointers[POINTER_SLOTS];
		bit walking;
		logic [1:0] levels_left;
		word_t offset_left;
		logic [4:0] span;
		logic [1:0] shift_code;
		bit first_data;
		word_t total;
		map_result_t pending[$];
		int failures;
		int reported;

		function new();
			foreach (pointers[i]) pointers[i] = '0;
			walking = 1'b0;
			levels_left = '0;
			offset_left = '0;
			span = '0;
			shift_code = 2'd0;
			first_data = 1'b1;
			total = '0;
			failures = 0;
			reported = 0;
		endfunction

		function void configure(cfg_index_t idx, word_t data);
			case (idx)
				CFG_BLOCK_SHIFT: shift_code = data[1:0];
				CFG_FIRST_DATA:  first_data = data[0];
				CFG_TOTAL:       total = data;
				default: ;
			endcase
		endfunction

		// index bits per pointer block; a code of three acts as two
		function int unsigned level_bits();
			return 8 + ((shift_code > 2'd2) ? 2 : int'(shift_code));
		endfunction

		function bit valid_block(word_t b);
			return b != 0 && b >= word_t'(first_data) && b < total;
		endfunction

		function void push(kind_t k, addr_t a, word_t b);
			map_result_t r;
			r.kind = k;
			r.addr = a;
			r.blk = b;
			pending.push_back(r);
		endfunction

		// one level of the walk with b as the current pointer block
		function void descend(word_t b);
			int unsigned ps;
			logic [63:0] idx;
			logic [63:0] a;
			ps = level_bits();
			if (b == 0) begin
				walking = 1'b0;
				push(KIND_DONE, '0, '0);
				return;
			end
			if (!valid_block(b)) begin
				walking = 1'b0;
				push(KIND_ERROR, '0, '0);
				return;
			end
			span = (int'(span) >= ps) ? 5'(int'(span) - ps) : 5'd0;
			idx = {32'd0, offset_left} >> span;
			offset_left = offset_left & word_t'((64'd1 << span) - 64'd1);
			// block size in bytes is 1 << (level bits + 2)
			a = ({32'd0, b} << (ps + 2)) + idx * 64'd4;
			walking = 1'b1;
			push(KIND_READ, a[ADDR_W-1:0], '0);
		endfunction

		// returns 1 when the transaction had any effect on the block
		function bit note_command(cmd_t c, slot_t s, word_t w, word_t lb);
			int unsigned ps;
			int unsigned sh;
			int unsigned lvl;
			logic [63:0] off;
			word_t b;
			case (c)
				CMD_LOAD: begin
					if (walking || s >= POINTER_SLOTS) return 1'b0;
					pointers[s] = w;
					return 1'b1;
				end
				CMD_MAP: begin
					if (walking) return 1'b0;
					if (lb < DIRECT_SLOTS) begin
						b = pointers[lb[3:0]];
						if (b == 0 || valid_block(b)) push(KIND_DONE, '0, b);
						else push(KIND_ERROR, '0, '0);
						return 1'b1;
					end
					ps = level_bits();
					off = {32'd0, lb} - DIRECT_SLOTS;
					sh = ps;
					lvl = 1;
					// find the indirect level whose span holds the offset
					while (lvl < 3 && off >= (64'd1 << sh)) begin
						off = off - (64'd1 << sh);
						sh = sh + ps;
						lvl = lvl + 1;
					end
					if (off >= (64'd1 << sh)) begin
						push(KIND_ERROR, '0, '0);
						return 1'b1;
					end
					levels_left = 2'(lvl);
					offset_left = off[31:0];
					span = sh[4:0];
					descend(pointers[DIRECT_SLOTS - 1 + lvl]);
					return 1'b1;
				end
				CMD_WORD: begin
					if (!walking) return 1'b0;
					levels_left = levels_left - 2'd1;
					if (levels_left == 0) begin
						walking = 1'b0;
						if (w != 0 && !valid_block(w)) push(KIND_ERROR, '0, '0);
						else push(KIND_DONE, '0, w);
					end else begin
						descend(w);
					end
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void check_result(kind_t k, addr_t a, word_t b);
			map_result_t exp_r;
			if (pending.size() == 0) begin
				failures++;
				if (reported < 10)
					$display("unexpected result: kind %0d addr %h block %h", k, a, b);
				reported++;
				return;
			end
			exp_r = pending.pop_front();
			if (exp_r.kind !== k || exp_r.addr !== a || exp_r.blk !== b) begin
				failures++;
				if (reported < 10)
					$display("mismatch: expected kind %0d addr %h block %h, got kind %0d addr %h block %h",
						exp_r.kind, exp_r.addr, exp_r.blk, k, a, b);
				reported++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_en;
	cfg_index_t cfg_index;
	word_t cfg_data;

	ibmw_in_if in_ch();
	ibmw_out_if out_ch();

	indirect_block_map_walker_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	map_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off_req;
	int items_done;
	int cycle_count;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog against a hung handshake
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result monitor: values read here are the ones the block saw at this edge
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.kind, out_ch.read_address, out_ch.mapped_block);
	end

	// receiver: random stalls, plus one long hold-off on request so the block backs up
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	// offer one transaction, wait for the handshake, then tell the scoreboard
	task automatic send_item(cmd_t c, slot_t s, word_t w, word_t lb);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.slot <= s;
		in_ch.word <= w;
		in_ch.logical_block <= lb;
		do @(posedge clk); while (!in_ch.ready);
		if (sb.note_command(c, s, w, lb)) items_done++;
	endtask

	// mostly a valid block for the current setting, with holes and bad blocks mixed in
	function automatic word_t pick_block();
		int r;
		r = $urandom_range(99, 0);
		if (r < 80 && sb.total >= 2) return $urandom_range(sb.total - 1, 1);
		if (r < 88) return '0;
		if (r < 95) begin
			if (sb.total == 0) return $urandom_range(32'hFFFF_FFFF, 1);
			return $urandom_range(32'hFFFF_FFFF, sb.total);
		end
		return $urandom;
	endfunction

	// logical block spread over the direct area, each indirect level and beyond
	function automatic word_t pick_logical();
		logic [63:0] p;
		logic [63:0] dbl_start;
		logic [63:0] tri_start;
		logic [63:0] beyond;
		int r;
		p = 64'd1 << sb.level_bits();
		dbl_start = DIRECT_SLOTS + p;
		tri_start = dbl_start + p * p;
		beyond = tri_start + p * p * p;
		r = $urandom_range(99, 0);
		if (r < 20) return $urandom_range(DIRECT_SLOTS - 1, 0);
		if (r < 45) return DIRECT_SLOTS + $urandom_range(32'(p - 1), 0);
		if (r < 65) return 32'(dbl_start) + $urandom_range(32'(p * p - 1), 0);
		if (r < 80) return 32'(tri_start) + $urandom_range(32'(p * p * p - 1), 0);
		if (r < 88) begin
			// edges of the levels
			case ($urandom_range(5, 0))
				0: return DIRECT_SLOTS - 1;
				1: return DIRECT_SLOTS;
				2: return 32'(dbl_start - 1);
				3: return 32'(dbl_start);
				4: return 32'(tri_start);
				default: return 32'(beyond - 1 + $urandom_range(1, 0));
			endcase
		end
		return $urandom;
	endfunction

	task automatic load_pointers();
		for (int i = 0; i < POINTER_SLOTS; i++)
			send_item(CMD_LOAD, slot_t'(i), pick_block(), $urandom);
	endtask

	// end any walk, let every owed result arrive, then a few quiet cycles
	task automatic settle();
		if (sb.walking) send_item(CMD_WORD, '0, '0, '0);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// registers go in back to back, enable dropped after the last one
	task automatic set_config(logic [1:0] bs, bit fdb, word_t tot);
		cfg_en <= 1'b1;
		cfg_index <= CFG_BLOCK_SHIFT;
		cfg_data <= word_t'(bs);
		@(posedge clk);
		sb.configure(CFG_BLOCK_SHIFT, word_t'(bs));
		cfg_index <= CFG_FIRST_DATA;
		cfg_data <= word_t'(fdb);
		@(posedge clk);
		sb.configure(CFG_FIRST_DATA, word_t'(fdb));
		cfg_index <= CFG_TOTAL;
		cfg_data <= tot;
		@(posedge clk);
		sb.configure(CFG_TOTAL, tot);
		cfg_en <= 1'b0;
	endtask

	// random traffic: mostly complete walks, some commands that the block drops
	task automatic run_random(int target);
		int goal;
		int r;
		goal = items_done + target;
		while (items_done < goal) begin
			r = $urandom_range(99, 0);
			if (sb.walking) begin
				if (r < 85) send_item(CMD_WORD, slot_t'($urandom), pick_block(), $urandom);
				else if (r < 92) send_item(CMD_MAP, slot_t'($urandom), $urandom, pick_logical());
				else send_item(CMD_LOAD, slot_t'($urandom), $urandom, $urandom);
			end else begin
				if (r < 60)
					send_item(CMD_MAP, slot_t'($urandom), $urandom, pick_logical());
				else if (r < 75)
					send_item(CMD_LOAD, slot_t'($urandom_range(15, 0)), pick_block(), $urandom);
				else if (r < 85)
					send_item(CMD_WORD, slot_t'($urandom), $urandom, $urandom);
				else if (r < 92)
					send_item(CMD_UNUSED, slot_t'($urandom), $urandom, $urandom);
				else
					send_item(CMD_MAP, slot_t'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		logic [1:0] phase_shift [PHASES];
		bit phase_first [PHASES];
		word_t phase_total;
		int mode;

		phase_shift = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1};
		phase_first = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

		// every input known from time zero
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = CFG_BLOCK_SHIFT;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_LOAD;
		in_ch.slot = '0;
		in_ch.word = '0;
		in_ch.logical_block = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b0;
		items_done = 0;
		sb = new();

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// defaults after reset: total of zero makes every non-zero block invalid
		load_pointers();
		send_item(CMD_MAP, '0, '0, 32'd0);
		send_item(CMD_MAP, '0, '0, 32'd12);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0, 2: phase_total = 32'hFFFF_FFFF;
				1: phase_total = $urandom_range(32'h8000_0000, 32'h0010_0000);
				3: phase_total = $urandom;
				4: phase_total = 32'd5000;
				default: phase_total = 32'd1;
			endcase
			set_config(phase_shift[ph], phase_first[ph], phase_total);

			// idling pattern of this phase
			mode = ph % 4;
			send_idle_pct = (mode == 1) ? 54 : (mode == 3) ? 37 : 0;
			recv_stall_pct = (mode == 2) ? 54 : (mode == 3) ? 37 : 0;

			load_pointers();

			if (ph == 0) begin
				// hand-picked pointers: hole, out of range, lowest block, indirect roots
				send_item(CMD_LOAD, 4'd0, 32'd0, '0);
				send_item(CMD_LOAD, 4'd1, 32'hFFFF_FFFF, '0);
				send_item(CMD_LOAD, 4'd2, 32'd1, '0);
				send_item(CMD_LOAD, 4'd12, 32'd100, '0);
				send_item(CMD_LOAD, 4'd13, 32'd200, '0);
				send_item(CMD_LOAD, 4'd14, 32'hFFFF_FFFE, '0);
				send_item(CMD_MAP, '0, '0, 32'd0);
				send_item(CMD_MAP, '0, '0, 32'd1);
				send_item(CMD_MAP, '0, '0, 32'd2);
				// first single indirect block; stray map and load during the walk are dropped
				send_item(CMD_MAP, '0, '0, 32'd12);
				send_item(CMD_MAP, '0, '0, 32'd5);
				send_item(CMD_LOAD, 4'd3, 32'd9, '0);
				send_item(CMD_WORD, '0, 32'd7, '0);
				// last single indirect block, returned word is a hole
				send_item(CMD_MAP, '0, '0, 32'd267);
				send_item(CMD_WORD, '0, 32'd0, '0);
				// double indirect ending on a bad block
				send_item(CMD_MAP, '0, '0, 32'd268);
				send_item(CMD_WORD, '0, 32'd300, '0);
				send_item(CMD_WORD, '0, 32'hFFFF_FFFF, '0);
				// full triple indirect walk
				send_item(CMD_MAP, '0, '0, 32'd65804);
				send_item(CMD_WORD, '0, 32'd1, '0);
				send_item(CMD_WORD, '0, 32'd2, '0);
				send_item(CMD_WORD, '0, 32'hFFFF_FFFE, '0);
				// beyond triple reach and the very top
				send_item(CMD_MAP, '0, '0, 32'd16843020);
				send_item(CMD_MAP, '0, '0, 32'hFFFF_FFFF);
				// returned word while idle, slot fifteen, unused command
				send_item(CMD_WORD, '0, 32'd5, '0);
				send_item(CMD_LOAD, 4'hF, 32'd5, '0);
				send_item(CMD_UNUSED, '0, '0, '0);
				// receiver goes quiet for a long stretch while traffic keeps coming
				hold_off_req = 1'b1;
			end

			run_random(ITEMS_PER_PHASE);
			settle();
		end

		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/ibmw_pkg.sv
design/ibmw_if.sv
design/ibmw_sub.sv
design/indirect_block_map_walker_top.sv
tb/indirect_block_map_walker_top_tb.sv
